/* rtl/core/dct1_forward_transform_top_defines.svh */
// Assertion macros for the DCT-I forward transform block.
// Used by the checker module; needs signals named clock and reset in scope.
`ifndef DCT1_FORWARD_TRANSFORM_TOP_DEFINES_SVH
`define DCT1_FORWARD_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DCT1_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCT1_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/dct1_pkg.sv */
// Shared types and constants for the DCT-I forward transform block.
// No dependencies; all other files but the macro header import it.
package dct1_pkg;

   localparam int NIntervalsDefault = 32;

   localparam int SampleWidth = 16;
   localparam int CoeffWidth  = 18;
   localparam int IndexWidth  = 6;

   localparam int CosWidth    = 17;
   localparam int CosDepth    = 64;
   localparam int PhaseWidth  = 6;
   localparam int ProdWidth   = SampleWidth + CosWidth;
   localparam int AccWidth    = 40;

   localparam int SumWidth    = AccWidth + 1;
   localparam int TruncWidth  = 26;
   localparam int OffsetWidth = 23;
   localparam int RecipShift  = 24;
   localparam int RecipWidth  = 24;

   localparam longint unsigned PiQ30 = 64'd3373259426;
   localparam int TaylorTerms = 10;
   localparam longint unsigned TaylorDen [TaylorTerms] =
      '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

   typedef logic signed [SampleWidth-1:0] sample_type;
   typedef logic signed [CoeffWidth-1:0]  coeff_type;
   typedef logic [IndexWidth-1:0]         index_type;
   typedef logic signed [AccWidth-1:0]    acc_type;
   typedef logic [CosDepth-1:0][CosWidth-1:0] cos_table_type;

   typedef struct packed {
      logic sample_valid;
      logic block_end;
      logic weight_two;
      logic shift_en;
   } cell_ctrl_type;

   typedef struct packed {
      acc_type   acc;
      index_type index;
      logic      last;
   } drain_word_type;

endpackage

/* rtl/core/dct1_if.sv */
// Sample and coefficient channel interfaces with valid/ready handshake.
// Depends on dct1_pkg for the payload types.
interface dct1_req_if;
   import dct1_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface dct1_rsp_if;
   import dct1_pkg::*;
   logic      valid;
   logic      ready;
   coeff_type coeff;
   index_type coeff_index;
   logic      last_coeff;
   modport source (output valid, output coeff, output coeff_index, output last_coeff,
                   input ready);
   modport sink (input valid, input coeff, input coeff_index, input last_coeff,
                 output ready);
endinterface

/* rtl/core/dct1_forward_transform_top.sv */
// Top level of the DCT-I forward transform: sample register, row of mode cells,
// drain control and output scaler. Depends on dct1_pkg, dct1_if, dct1_cell, dct1_scaler.
//
//   Channel    Role     Payload                             Handshake
//   req_chan   sink     sample (Q1.15)                      valid/ready
//   rsp_chan   source   coeff (Q3.15), coeff_index, last    valid/ready
//
// During accumulation one sample word is taken every cycle; each of the N+1 cells
// multiplies it by its cosine and adds it into its own accumulator.
// After the last sample of a block, input stalls while the cell pipeline settles and
// the row shifts its N+1 accumulators out, one per cycle unless rsp_chan stalls, into
// the four-stage scaler.
// A stall on rsp_chan holds the scaler and the shift of the cell row.
// Reset is synchronous and clears all accumulators, phases and counters.
module dct1_forward_transform_top #(
   parameter int N_INTERVALS = dct1_pkg::NIntervalsDefault
) (
   input logic        clock,
   input logic        reset,
   dct1_req_if.sink   req_chan,
   dct1_rsp_if.source rsp_chan
);
   import dct1_pkg::*;

   localparam logic [1:0] StAccum  = 2'd0;
   localparam logic [1:0] StSettle = 2'd1;
   localparam logic [1:0] StDrain  = 2'd2;

   localparam index_type LastIndex = IndexWidth'(N_INTERVALS);

   function automatic cos_table_type build_cos_table();
      cos_table_type     tbl;
      longint unsigned   x, x2, term, q;
      longint            sum;
      longint unsigned   r;
      logic              neg;
      int                m, n;
      tbl = '0;
      for (m = 0; m < CosDepth; m++) begin
         if (m < 2 * N_INTERVALS) begin
            r = longint'(m);
            neg = 1'b0;
            if (r > longint'(N_INTERVALS)) begin
               r = longint'(2 * N_INTERVALS) - r;
            end
            if (2 * r > longint'(N_INTERVALS)) begin
               r = longint'(N_INTERVALS) - r;
               neg = 1'b1;
            end
            x = (PiQ30 * r) / N_INTERVALS;
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            sum = longint'(term);
            for (n = 1; n <= TaylorTerms; n++) begin
               term = ((term * x2) >> 30) / TaylorDen[n-1];
               if (n % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            if (sum < 0) begin
               sum = 0;
            end
            q = longint'(sum + 16384) >> 15;
            if (q > 64'd32768) begin
               q = 64'd32768;
            end
            tbl[m] = neg ? -CosWidth'(q) : CosWidth'(q);
         end
      end
      return tbl;
   endfunction

   localparam cos_table_type CosTable = build_cos_table();

   logic [1:0]  state_ff, state_in;
   index_type   pos_ff, pos_in;
   index_type   drain_idx_ff, drain_idx_in;
   sample_type  in_sample_ff;
   logic        in_valid_ff, in_last_ff, in_wt2_ff;
   logic        last_prod_ff;
   logic        req_fire, pos_last;
   logic        drain_valid, drain_ready, drain_fire;
   drain_word_type drain_word;
   cell_ctrl_type  cell_ctrl;
   acc_type     cell_acc [N_INTERVALS+1];

   assign req_chan.ready = (state_ff == StAccum);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign pos_last       = (pos_ff == LastIndex);
   assign drain_valid    = (state_ff == StDrain);
   assign drain_fire     = drain_valid && drain_ready;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      drain_idx_in = drain_idx_ff;
      unique case (state_ff)
         StAccum: begin
            if (req_fire) begin
               if (pos_last) begin
                  pos_in   = '0;
                  state_in = StSettle;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         StSettle: begin
            if (last_prod_ff) begin
               state_in = StDrain;
            end
         end
         StDrain: begin
            if (drain_fire) begin
               if (drain_idx_ff == LastIndex) begin
                  drain_idx_in = '0;
                  state_in     = StAccum;
               end else begin
                  drain_idx_in = drain_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = StAccum;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StAccum;
         pos_ff       <= '0;
         drain_idx_ff <= '0;
         in_valid_ff  <= 1'b0;
         in_last_ff   <= 1'b0;
         last_prod_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         drain_idx_ff <= drain_idx_in;
         in_valid_ff  <= req_fire;
         in_last_ff   <= req_fire && pos_last;
         last_prod_ff <= in_valid_ff && in_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_sample_ff <= req_chan.sample;
         in_wt2_ff    <= (pos_ff != '0) && !pos_last;
      end
   end

   assign cell_ctrl.sample_valid = in_valid_ff;
   assign cell_ctrl.block_end    = in_last_ff;
   assign cell_ctrl.weight_two   = in_wt2_ff;
   assign cell_ctrl.shift_en     = drain_fire;

   for (genvar k = 0; k <= N_INTERVALS; k++) begin : g_cell
      acc_type shift_src;
      if (k == N_INTERVALS) begin : g_tail
         assign shift_src = '0;
      end else begin : g_link
         assign shift_src = cell_acc[k+1];
      end
      dct1_cell #(
         .N_INTERVALS (N_INTERVALS),
         .CELL_INDEX  (k),
         .COS_TABLE   (CosTable)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .sample       (in_sample_ff),
         .acc_shift_in (shift_src),
         .acc_out      (cell_acc[k])
      );
   end

   assign drain_word.acc   = cell_acc[0];
   assign drain_word.index = drain_idx_ff;
   assign drain_word.last  = (drain_idx_ff == LastIndex);

   dct1_scaler #(
      .N_INTERVALS (N_INTERVALS)
   ) u_scaler (
      .clock       (clock),
      .reset       (reset),
      .drain_valid (drain_valid),
      .drain_word  (drain_word),
      .drain_ready (drain_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule

/* rtl/core/dct1_cell.sv */
// One mode cell of the DCT-I row: cosine phase, product register and accumulator.
// Depends on dct1_pkg; the cosine table comes in as a parameter.
module dct1_cell #(
   parameter int N_INTERVALS = dct1_pkg::NIntervalsDefault,
   parameter int CELL_INDEX = 0,
   parameter dct1_pkg::cos_table_type COS_TABLE = '0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dct1_pkg::cell_ctrl_type ctrl,
   input  dct1_pkg::sample_type    sample,
   input  dct1_pkg::acc_type       acc_shift_in,
   output dct1_pkg::acc_type       acc_out
);
   import dct1_pkg::*;

   localparam int TwoN = 2 * N_INTERVALS;
   localparam int PhaseSumWidth = PhaseWidth + 1;

   logic [PhaseWidth-1:0]      phase_ff, phase_in;
   logic [PhaseSumWidth-1:0]   phase_sum;
   logic signed [CosWidth-1:0] cos_val;
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic                       prod_valid_ff;
   logic                       prod_wt2_ff;
   acc_type                    acc_ff, acc_in, addend;

   always_comb begin
      phase_sum = {1'b0, phase_ff} + PhaseSumWidth'(CELL_INDEX);
      if (ctrl.block_end) begin
         phase_in = '0;
      end else if (phase_sum >= PhaseSumWidth'(TwoN)) begin
         phase_in = PhaseWidth'(phase_sum - PhaseSumWidth'(TwoN));
      end else begin
         phase_in = PhaseWidth'(phase_sum);
      end
   end

   assign cos_val = COS_TABLE[phase_ff];
   assign prod_in = sample * cos_val;
   assign addend  = prod_wt2_ff ? (AccWidth'(prod_ff) <<< 1) : AccWidth'(prod_ff);

   always_comb begin
      if (ctrl.shift_en) begin
         acc_in = acc_shift_in;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         prod_valid_ff <= ctrl.sample_valid;
         if (ctrl.sample_valid) begin
            phase_ff <= phase_in;
         end
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.sample_valid) begin
         prod_ff     <= prod_in;
         prod_wt2_ff <= ctrl.weight_two;
      end
   end

   assign acc_out = acc_ff;

endmodule

/* rtl/core/dct1_scaler.sv */
// Output scaler: rounds a drained accumulator by 2/N (1/N at modes 0 and N),
// saturates to Q3.15, holds the result. Depends on dct1_pkg, dct1_rsp_if.
module dct1_scaler #(
   parameter int N_INTERVALS = dct1_pkg::NIntervalsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     drain_valid,
   input  dct1_pkg::drain_word_type drain_word,
   output logic                     drain_ready,
   dct1_rsp_if.source               rsp_chan
);
   import dct1_pkg::*;

   localparam int SatSpan = (1 << (CoeffWidth - 1)) * N_INTERVALS;
   localparam logic signed [SumWidth-1:0] RoundNormal = SumWidth'(N_INTERVALS * 16384);
   localparam logic signed [SumWidth-1:0] RoundEdge = SumWidth'(N_INTERVALS * 32768);
   localparam logic signed [TruncWidth-1:0] TruncHigh = TruncWidth'(SatSpan - 1);
   localparam logic signed [TruncWidth-1:0] TruncLow = TruncWidth'(-SatSpan);
   localparam logic signed [TruncWidth-1:0] TruncOffset = TruncWidth'(SatSpan);
   localparam logic [RecipWidth-1:0] Recip = RecipWidth'((1 << RecipShift) / N_INTERVALS);
   localparam logic [OffsetWidth-1:0] NDivisor = OffsetWidth'(N_INTERVALS);

   logic advance;
   logic edge_mode;
   logic signed [SumWidth-1:0]   round_sum;
   logic signed [TruncWidth-1:0] trunc_in, trunc_ff, trunc_clamp;
   logic [OffsetWidth-1:0]       offset_in, offset_ff, offset3_ff;
   logic [OffsetWidth+RecipWidth-1:0] recip_prod;
   logic [CoeffWidth-1:0]        quot_est_ff, quot_final;
   logic [OffsetWidth-1:0]       back_prod, remainder;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   index_type s1_index_ff, s2_index_ff, s3_index_ff, out_index_ff;
   logic s1_last_ff, s2_last_ff, s3_last_ff, out_last_ff;
   coeff_type out_coeff_ff;

   assign advance     = !out_valid_ff || rsp_chan.ready;
   assign drain_ready = advance;

   assign edge_mode = (drain_word.index == '0) ||
                      (drain_word.index == IndexWidth'(N_INTERVALS));
   assign round_sum = SumWidth'(drain_word.acc) + (edge_mode ? RoundEdge : RoundNormal);
   assign trunc_in  = edge_mode ? TruncWidth'(round_sum >>> 16) : TruncWidth'(round_sum >>> 15);

   always_comb begin
      if (trunc_ff > TruncHigh) begin
         trunc_clamp = TruncHigh;
      end else if (trunc_ff < TruncLow) begin
         trunc_clamp = TruncLow;
      end else begin
         trunc_clamp = trunc_ff;
      end
   end

   assign offset_in  = OffsetWidth'(trunc_clamp + TruncOffset);
   assign recip_prod = offset_ff * Recip;
   assign back_prod  = OffsetWidth'(quot_est_ff) * NDivisor;
   assign remainder  = offset3_ff - back_prod;
   assign quot_final = (remainder >= NDivisor) ? quot_est_ff + 1'b1 : quot_est_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= drain_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         trunc_ff     <= trunc_in;
         s1_index_ff  <= drain_word.index;
         s1_last_ff   <= drain_word.last;
         offset_ff    <= offset_in;
         s2_index_ff  <= s1_index_ff;
         s2_last_ff   <= s1_last_ff;
         quot_est_ff  <= recip_prod[RecipShift +: CoeffWidth];
         offset3_ff   <= offset_ff;
         s3_index_ff  <= s2_index_ff;
         s3_last_ff   <= s2_last_ff;
         out_coeff_ff <= {~quot_final[CoeffWidth-1], quot_final[CoeffWidth-2:0]};
         out_index_ff <= s3_index_ff;
         out_last_ff  <= s3_last_ff;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.coeff       = out_coeff_ff;
   assign rsp_chan.coeff_index = out_index_ff;
   assign rsp_chan.last_coeff  = out_last_ff;

endmodule

/* rtl/core/dct1_checker.sv */
// Port-level checks on the coefficient channel of the DCT-I block, bound to the top.
// Depends on dct1_pkg and the assertion macros in dct1_forward_transform_top_defines.svh.
`include "dct1_forward_transform_top_defines.svh"

module dct1_checker #(
   parameter int N_INTERVALS = dct1_pkg::NIntervalsDefault
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dct1_pkg::coeff_type  rsp_coeff,
   input dct1_pkg::index_type  rsp_coeff_index,
   input logic                 rsp_last_coeff
);
   import dct1_pkg::*;

   index_type expect_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_index_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         if (rsp_last_coeff) begin
            expect_index_ff <= '0;
         end else begin
            expect_index_ff <= expect_index_ff + 1'b1;
         end
      end
   end

   // A stalled coefficient word stays in place.
   `DCT1_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_coeff) && $stable(rsp_coeff_index) && $stable(rsp_last_coeff), "coefficient word changed while stalled")

   // Coefficients leave in mode order and start over after the last one.
   `DCT1_ASSERT_IMPLY(a_index_order, rsp_valid, rsp_coeff_index == expect_index_ff, "coefficient index out of order")

   // The last flag marks exactly the highest mode.
   `DCT1_ASSERT_IMPLY(a_last_flag, rsp_valid, rsp_last_coeff == (rsp_coeff_index == IndexWidth'(N_INTERVALS)), "last flag does not match the highest mode")

endmodule

bind dct1_forward_transform_top dct1_checker #(
   .N_INTERVALS (N_INTERVALS)
) u_dct1_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_coeff       (rsp_chan.coeff),
   .rsp_coeff_index (rsp_chan.coeff_index),
   .rsp_last_coeff  (rsp_chan.last_coeff)
);
